// File: rtl/sdt_pkg.sv
// ----------------------------------------------------------------------------
// Shader constant dirty tracker package
// Shared types, command codes and reset values for the tracker blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package sdt_pkg;

  // Widths of the fixed fields, and the number of banks.
  localparam int unsigned MarkW  = 12;
  localparam int unsigned CountW = 16;
  localparam int unsigned NumBanks = 6;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [CountW-1:0] VERTEX_FLOAT_LIMIT_RST = 16'd256;
  localparam logic [CountW-1:0] PIXEL_FLOAT_LIMIT_RST  = 16'd224;
  localparam logic [CountW-1:0] INT_LIMIT_RST          = 16'd16;
  localparam logic [CountW-1:0] BOOL_LIMIT_RST         = 16'd16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_VERTEX_FLOAT_LIMIT = 2'd0,
    REG_PIXEL_FLOAT_LIMIT  = 2'd1,
    REG_INT_LIMIT          = 2'd2,
    REG_BOOL_LIMIT         = 2'd3
  } reg_idx_e;

  // Command codes as they arrive on the request port.
  typedef enum logic [2:0] {
    MODE_CONST_SET  = 3'd0,
    MODE_SET_MARKS  = 3'd1,
    MODE_CLEAR_MARKS = 3'd2,
    MODE_MARK_ALL   = 3'd3,
    MODE_BUILD_PLAN = 3'd4
  } mode_e;

  // Classified operations handed to the back end.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CONST_SET,
    OP_SET_MARKS,
    OP_CLEAR_MARKS,
    OP_MARK_ALL,
    OP_BUILD_PLAN
  } op_e;

  // One classified command.
  typedef struct packed {
    op_e               op;
    logic [2:0]        bank;
    logic              stage;
    logic [CountW-1:0] cand;
    logic [MarkW-1:0]  marks;
    logic              full;
    logic [CountW-1:0] use_float;
    logic [CountW-1:0] use_int;
    logic [CountW-1:0] use_bool;
  } cmd_t;

  // Upload limits.
  typedef struct packed {
    logic [CountW-1:0] vertex_float;
    logic [CountW-1:0] pixel_float;
    logic [CountW-1:0] int_lim;
    logic [CountW-1:0] bool_lim;
  } limits_t;

  // One result.
  typedef struct packed {
    logic [MarkW-1:0]  dirty_marks;
    logic              plan_valid;
    logic [CountW-1:0] plan_float;
    logic [CountW-1:0] plan_int;
    logic [CountW-1:0] plan_bool;
    logic              full_struct;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/sdt_front.sv
// ----------------------------------------------------------------------------
// Tracker front end
// Classifies each incoming request and computes its saturated end register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_front (
  input  wire logic [2:0]                  mode_i,
  input  wire logic [2:0]                  bank_i,
  input  wire logic                        stage_i,
  input  wire logic [31:0]                 start_reg_i,
  input  wire logic [31:0]                 reg_count_i,
  input  wire logic [sdt_pkg::MarkW-1:0]   bit_mask_i,
  input  wire logic                        usage_unknown_i,
  input  wire logic [2:0]                  usage_indexed_i,
  input  wire logic [sdt_pkg::CountW-1:0]  usage_float_count_i,
  input  wire logic [sdt_pkg::CountW-1:0]  usage_int_count_i,
  input  wire logic [sdt_pkg::CountW-1:0]  usage_bool_count_i,
  output sdt_pkg::cmd_t                    cmd_o
);

  logic [32:0] end_sum;

  // The end of a written range, saturated to the counter width.
  assign end_sum = {1'b0, start_reg_i} + {1'b0, reg_count_i};

  always_comb begin
    cmd_o.bank      = bank_i;
    cmd_o.stage     = stage_i;
    cmd_o.cand      = (|end_sum[32:sdt_pkg::CountW]) ? '1 : end_sum[sdt_pkg::CountW-1:0];
    cmd_o.marks     = bit_mask_i;
    cmd_o.full      = usage_unknown_i || (usage_indexed_i != 3'd0);
    cmd_o.use_float = usage_float_count_i;
    cmd_o.use_int   = usage_int_count_i;
    cmd_o.use_bool  = usage_bool_count_i;
    // A constant set to a bank that does not exist does nothing.
    case (mode_i)
      sdt_pkg::MODE_CONST_SET: begin
        cmd_o.op = (bank_i < 3'(sdt_pkg::NumBanks)) ? sdt_pkg::OP_CONST_SET
                                                     : sdt_pkg::OP_NOP;
      end
      sdt_pkg::MODE_SET_MARKS:   cmd_o.op = sdt_pkg::OP_SET_MARKS;
      sdt_pkg::MODE_CLEAR_MARKS: cmd_o.op = sdt_pkg::OP_CLEAR_MARKS;
      sdt_pkg::MODE_MARK_ALL:    cmd_o.op = sdt_pkg::OP_MARK_ALL;
      sdt_pkg::MODE_BUILD_PLAN:  cmd_o.op = sdt_pkg::OP_BUILD_PLAN;
      default:                   cmd_o.op = sdt_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/sdt_queue.sv
// ----------------------------------------------------------------------------
// Tracker command queue
// A short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_queue #(
  parameter int unsigned Depth = sdt_pkg::QUEUE_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire sdt_pkg::cmd_t push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output sdt_pkg::cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sdt_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count updates, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The fill count never goes past the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count exceeds depth");

  // The read pointer moves only when an entry leaves.
  a_rd_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !do_pop |=> $stable(rd_ptr_q))
    else $error("queue read pointer moved without a pop");

endmodule

`default_nettype wire

// File: rtl/sdt_back.sv
// ----------------------------------------------------------------------------
// Tracker back end
// Applies commands to the dirty mask and counters and builds upload plans.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire sdt_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  wire sdt_pkg::limits_t limits_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output sdt_pkg::result_t res_o
);

  logic [sdt_pkg::MarkW-1:0]  mask_q, mask_d;
  logic [sdt_pkg::CountW-1:0] hw_q [sdt_pkg::NumBanks];
  logic [sdt_pkg::CountW-1:0] hw_d [sdt_pkg::NumBanks];
  logic                       res_valid_q;
  sdt_pkg::result_t           res_q, res_d;
  logic [sdt_pkg::CountW-1:0] cnt_f, cnt_i, cnt_b, lim_f;

  // Take a command whenever the output register is free or being drained.
  assign cmd_pop_o   = cmd_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Larger of counter and usage, clamped to the limit.
  function automatic logic [sdt_pkg::CountW-1:0] plan_count(
    input logic [sdt_pkg::CountW-1:0] cnt,
    input logic [sdt_pkg::CountW-1:0] use_cnt,
    input logic [sdt_pkg::CountW-1:0] lim
  );
    logic [sdt_pkg::CountW-1:0] v;
    v = (cnt > use_cnt) ? cnt : use_cnt;
    return (v < lim) ? v : lim;
  endfunction

  // Counters of the planned stage.
  assign cnt_f = cmd_i.stage ? hw_q[3] : hw_q[0];
  assign cnt_i = cmd_i.stage ? hw_q[4] : hw_q[1];
  assign cnt_b = cmd_i.stage ? hw_q[5] : hw_q[2];
  assign lim_f = cmd_i.stage ? limits_i.pixel_float : limits_i.vertex_float;

  // State update and result for the command at the queue head.
  always_comb begin
    mask_d = mask_q;
    for (int i = 0; i < sdt_pkg::NumBanks; i++) begin
      hw_d[i] = hw_q[i];
    end
    res_d = '0;
    case (cmd_i.op)
      sdt_pkg::OP_CONST_SET: begin
        for (int i = 0; i < sdt_pkg::NumBanks; i++) begin
          if (cmd_i.bank == 3'(i)) begin
            mask_d[i] = 1'b1;
            if (cmd_i.cand > hw_q[i]) begin
              hw_d[i] = cmd_i.cand;
            end
          end
        end
      end
      sdt_pkg::OP_SET_MARKS:   mask_d = mask_q | cmd_i.marks;
      sdt_pkg::OP_CLEAR_MARKS: mask_d = mask_q & ~cmd_i.marks;
      sdt_pkg::OP_MARK_ALL:    mask_d = '1;
      sdt_pkg::OP_BUILD_PLAN: begin
        res_d.plan_valid = 1'b1;
        if (cmd_i.full) begin
          res_d.plan_float  = lim_f;
          res_d.plan_int    = limits_i.int_lim;
          res_d.plan_bool   = limits_i.bool_lim;
          res_d.full_struct = 1'b1;
        end else begin
          res_d.plan_float = plan_count(cnt_f, cmd_i.use_float, lim_f);
          res_d.plan_int   = plan_count(cnt_i, cmd_i.use_int, limits_i.int_lim);
          res_d.plan_bool  = plan_count(cnt_b, cmd_i.use_bool, limits_i.bool_lim);
        end
      end
      default: ;
    endcase
    res_d.dirty_marks = mask_d;
  end

  // Tracker state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < sdt_pkg::NumBanks; i++) begin
        hw_q[i] <= '0;
      end
    end else begin
      if (cmd_pop_o) begin
        mask_q      <= mask_d;
        res_valid_q <= 1'b1;
        for (int i = 0; i < sdt_pkg::NumBanks; i++) begin
          hw_q[i] <= hw_d[i];
        end
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

  // A result without a plan carries zero plan fields.
  a_no_plan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.plan_valid |->
      res_q.plan_float == '0 && res_q.plan_int == '0 &&
      res_q.plan_bool == '0 && !res_q.full_struct)
    else $error("non-plan result has plan fields set");

  // Integer and boolean plan counts never exceed their limits.
  a_plan_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.plan_valid |->
      res_q.plan_int <= limits_i.int_lim && res_q.plan_bool <= limits_i.bool_lim)
    else $error("plan count above limit");

  // Mark-all leaves every mark set in its result.
  a_mark_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o && cmd_i.op == sdt_pkg::OP_MARK_ALL |=> res_q.dirty_marks == '1)
    else $error("mark-all result lost marks");

endmodule

`default_nettype wire

// File: rtl/shader_constant_dirty_tracker.sv
// ----------------------------------------------------------------------------
// Shader constant dirty tracker
// Keeps dirty marks and per-bank high-water counters and builds upload plans.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   request   in         in_valid_i/in_ready_o  mode_i .. usage_bool_count_i
//   result    out        out_valid_o/out_ready_i dirty_marks_o .. full_struct_o
//   config    in         cfg_write_i            cfg_index_i, cfg_data_i
//
// A request is classified in the cycle it is accepted and queued; the back
// end applies it from the queue head and registers its result in the
// result register. One request per cycle is sustained while out_ready_i
// stays high; the back end's single state update per cycle sets that
// figure. The queue holds QueueDepth requests behind the result register;
// once it is full, in_ready_o drops until the result port drains. Reset
// clears the marks and counters and restores the limit defaults at once.
// ----------------------------------------------------------------------------
`default_nettype none

module shader_constant_dirty_tracker #(
  parameter int unsigned QueueDepth = sdt_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration writes.
  input  wire logic                       cfg_write_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [15:0]                cfg_data_i,
  // Request channel.
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [2:0]                 mode_i,
  input  wire logic [2:0]                 bank_i,
  input  wire logic                       stage_i,
  input  wire logic [31:0]                start_reg_i,
  input  wire logic [31:0]                reg_count_i,
  input  wire logic [11:0]                bit_mask_i,
  input  wire logic                       usage_unknown_i,
  input  wire logic [2:0]                 usage_indexed_i,
  input  wire logic [15:0]                usage_float_count_i,
  input  wire logic [15:0]                usage_int_count_i,
  input  wire logic [15:0]                usage_bool_count_i,
  // Result channel.
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [11:0]                     dirty_marks_o,
  output logic                            plan_valid_o,
  output logic [15:0]                     plan_float_count_o,
  output logic [15:0]                     plan_int_count_o,
  output logic [15:0]                     plan_bool_count_o,
  output logic                            full_struct_o
);

  sdt_pkg::limits_t limits_q;
  sdt_pkg::cmd_t    front_cmd, head_cmd;
  sdt_pkg::result_t res;
  logic             q_full, q_valid, q_pop;

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.vertex_float <= sdt_pkg::VERTEX_FLOAT_LIMIT_RST;
      limits_q.pixel_float  <= sdt_pkg::PIXEL_FLOAT_LIMIT_RST;
      limits_q.int_lim      <= sdt_pkg::INT_LIMIT_RST;
      limits_q.bool_lim     <= sdt_pkg::BOOL_LIMIT_RST;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        sdt_pkg::REG_VERTEX_FLOAT_LIMIT: limits_q.vertex_float <= cfg_data_i;
        sdt_pkg::REG_PIXEL_FLOAT_LIMIT:  limits_q.pixel_float  <= cfg_data_i;
        sdt_pkg::REG_INT_LIMIT:          limits_q.int_lim      <= cfg_data_i;
        sdt_pkg::REG_BOOL_LIMIT:         limits_q.bool_lim     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: classify the incoming request.
  sdt_front u_front (
    .mode_i              (mode_i),
    .bank_i              (bank_i),
    .stage_i             (stage_i),
    .start_reg_i         (start_reg_i),
    .reg_count_i         (reg_count_i),
    .bit_mask_i          (bit_mask_i),
    .usage_unknown_i     (usage_unknown_i),
    .usage_indexed_i     (usage_indexed_i),
    .usage_float_count_i (usage_float_count_i),
    .usage_int_count_i   (usage_int_count_i),
    .usage_bool_count_i  (usage_bool_count_i),
    .cmd_o               (front_cmd)
  );

  assign in_ready_o = !q_full;

  // Queue between front and back.
  sdt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (head_cmd)
  );

  // Back end: apply commands and register results.
  sdt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .limits_i    (limits_q),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign dirty_marks_o      = res.dirty_marks;
  assign plan_valid_o       = res.plan_valid;
  assign plan_float_count_o = res.plan_float;
  assign plan_int_count_o   = res.plan_int;
  assign plan_bool_count_o  = res.plan_bool;
  assign full_struct_o      = res.full_struct;

endmodule

`default_nettype wire

// File: bench/shader_constant_dirty_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader constant dirty tracker testbench
// Drives command requests through the valid/ready request channel and checks
// every result field against a cycle-free model of the marks, the high-water
// counters and the upload limits. A short directed table is followed by
// random phases, each under its own set of limits, with random idling on
// both channels, one long result stall and one full drain mid-phase.
// ----------------------------------------------------------------------------

module shader_constant_dirty_tracker_tb;
  import sdt_pkg::*;

  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned NumDirected = 25;
  localparam int unsigned MaxGap = 18;
  localparam int unsigned LongHold = 80;
  localparam int unsigned DrainLimit = 5000;
  localparam int unsigned ReportLimit = 10;

  // One command request as it is driven on the ports.
  typedef struct {
    logic [2:0]        mode;
    logic [2:0]        bank;
    logic              stage;
    logic [31:0]       start_reg;
    logic [31:0]       reg_count;
    logic [MarkW-1:0]  marks;
    logic              unknown;
    logic [2:0]        indexed;
    logic [CountW-1:0] use_float;
    logic [CountW-1:0] use_int;
    logic [CountW-1:0] use_bool;
  } tracker_cmd_t;

  // A directed row, with its result written out where it is obvious.
  typedef struct {
    tracker_cmd_t cmd;
    logic         fixed;
    result_t      want;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_write_i;
  logic [1:0]        cfg_index_i;
  logic [15:0]       cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [2:0]        mode_i;
  logic [2:0]        bank_i;
  logic              stage_i;
  logic [31:0]       start_reg_i;
  logic [31:0]       reg_count_i;
  logic [11:0]       bit_mask_i;
  logic              usage_unknown_i;
  logic [2:0]        usage_indexed_i;
  logic [15:0]       usage_float_count_i;
  logic [15:0]       usage_int_count_i;
  logic [15:0]       usage_bool_count_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [11:0]       dirty_marks_o;
  logic              plan_valid_o;
  logic [15:0]       plan_float_count_o;
  logic [15:0]       plan_int_count_o;
  logic [15:0]       plan_bool_count_o;
  logic              full_struct_o;

  // Model state of the tracker.
  logic [MarkW-1:0]  model_marks;
  logic [CountW-1:0] model_water [NumBanks];
  limits_t           model_limits;

  result_t           pending_results [$];
  int unsigned       fail_count = 0;
  int unsigned       reported = 0;
  bit                hold_results = 1'b0;
  bit                receiver_idle = 1'b1;

  shader_constant_dirty_tracker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_write_i        (cfg_write_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .bank_i             (bank_i),
    .stage_i            (stage_i),
    .start_reg_i        (start_reg_i),
    .reg_count_i        (reg_count_i),
    .bit_mask_i         (bit_mask_i),
    .usage_unknown_i    (usage_unknown_i),
    .usage_indexed_i    (usage_indexed_i),
    .usage_float_count_i(usage_float_count_i),
    .usage_int_count_i  (usage_int_count_i),
    .usage_bool_count_i (usage_bool_count_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .dirty_marks_o      (dirty_marks_o),
    .plan_valid_o       (plan_valid_o),
    .plan_float_count_o (plan_float_count_o),
    .plan_int_count_o   (plan_int_count_o),
    .plan_bool_count_o  (plan_bool_count_o),
    .full_struct_o      (full_struct_o)
  );

  // Clock with an 8 ns period.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Upload count for one constant kind: the larger of counter and usage,
  // clamped to the limit.
  function automatic logic [CountW-1:0] upload_count(logic [CountW-1:0] water,
                                                     logic [CountW-1:0] usage,
                                                     logic [CountW-1:0] limit);
    logic [CountW-1:0] need;
    need = (water > usage) ? water : usage;
    return (need < limit) ? need : limit;
  endfunction

  // Applies one accepted request to the model state and returns its result.
  function automatic result_t apply_command(tracker_cmd_t c);
    result_t           res;
    logic [32:0]       span_end;
    logic [CountW-1:0] cand;
    logic [CountW-1:0] float_lim;
    int unsigned       base;
    res = '0;
    case (c.mode)
      MODE_CONST_SET: begin
        // Banks six and seven do not exist and leave everything alone.
        if (c.bank < NumBanks) begin
          span_end = {1'b0, c.start_reg} + {1'b0, c.reg_count};
          cand = (span_end > 33'd65535) ? 16'hFFFF : span_end[15:0];
          model_marks[c.bank] = 1'b1;
          if (cand > model_water[c.bank]) model_water[c.bank] = cand;
        end
      end
      MODE_SET_MARKS:   model_marks = model_marks | c.marks;
      MODE_CLEAR_MARKS: model_marks = model_marks & ~c.marks;
      MODE_MARK_ALL:    model_marks = '1;
      MODE_BUILD_PLAN: begin
        base = c.stage ? 3 : 0;
        float_lim = c.stage ? model_limits.pixel_float : model_limits.vertex_float;
        res.plan_valid = 1'b1;
        // Unknown or relatively indexed usage forces the whole structure.
        if (c.unknown || c.indexed != 3'd0) begin
          res.plan_float = float_lim;
          res.plan_int = model_limits.int_lim;
          res.plan_bool = model_limits.bool_lim;
          res.full_struct = 1'b1;
        end else begin
          res.plan_float = upload_count(model_water[base], c.use_float, float_lim);
          res.plan_int = upload_count(model_water[base+1], c.use_int, model_limits.int_lim);
          res.plan_bool = upload_count(model_water[base+2], c.use_bool,
                                       model_limits.bool_lim);
        end
      end
      default: ;
    endcase
    res.dirty_marks = model_marks;
    return res;
  endfunction

  function automatic tracker_cmd_t command(logic [2:0] mode, logic [2:0] bank,
                                           logic stage, logic [31:0] start_reg,
                                           logic [31:0] reg_count, logic [11:0] marks,
                                           logic unknown, logic [2:0] indexed,
                                           logic [15:0] uf, logic [15:0] ui,
                                           logic [15:0] ub);
    tracker_cmd_t c;
    c.mode = mode;
    c.bank = bank;
    c.stage = stage;
    c.start_reg = start_reg;
    c.reg_count = reg_count;
    c.marks = marks;
    c.unknown = unknown;
    c.indexed = indexed;
    c.use_float = uf;
    c.use_int = ui;
    c.use_bool = ub;
    return c;
  endfunction

  function automatic result_t typed_result(logic [11:0] marks, logic valid,
                                           logic [15:0] pf, logic [15:0] pi,
                                           logic [15:0] pb, logic full);
    result_t res;
    res.dirty_marks = marks;
    res.plan_valid = valid;
    res.plan_float = pf;
    res.plan_int = pi;
    res.plan_bool = pb;
    res.full_struct = full;
    return res;
  endfunction

  // Random request; large and saturating ranges only when wide is set, so the
  // counters stay below saturation for most of the run.
  function automatic tracker_cmd_t random_command(bit wide);
    tracker_cmd_t c;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    if (pick < 22)      c.mode = MODE_CONST_SET;
    else if (pick < 34) c.mode = MODE_SET_MARKS;
    else if (pick < 44) c.mode = MODE_CLEAR_MARKS;
    else if (pick < 48) c.mode = MODE_MARK_ALL;
    else if (pick < 94) c.mode = MODE_BUILD_PLAN;
    else                c.mode = 3'($urandom_range(5, 7));
    c.bank = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
    c.stage = 1'($urandom_range(0, 1));
    if (wide && $urandom_range(0, 3) == 0) begin
      c.start_reg = $urandom();
      c.reg_count = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 8);
    end else begin
      c.start_reg = $urandom_range(0, 2500);
      c.reg_count = $urandom_range(0, 600);
    end
    c.marks = 12'($urandom_range(0, 4095));
    c.unknown = ($urandom_range(0, 9) == 0);
    c.indexed = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    c.use_float = $urandom_range(0, 1) ? 16'($urandom_range(0, 400))
                                       : 16'($urandom_range(0, 65535));
    c.use_int = $urandom_range(0, 1) ? 16'($urandom_range(0, 40))
                                     : 16'($urandom_range(0, 65535));
    c.use_bool = $urandom_range(0, 1) ? 16'($urandom_range(0, 40))
                                      : 16'($urandom_range(0, 65535));
    return c;
  endfunction

  function automatic int unsigned draw_gap(bit enabled);
    return enabled ? $urandom_range(0, MaxGap) : 0;
  endfunction

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (reported < ReportLimit) begin
        reported++;
        $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, want,
                 got);
      end
    end
  endtask

  // Offers one request after an idle gap and records its expected result
  // once it is accepted. A fixed row supplies its own expectation.
  task automatic send_request(tracker_cmd_t c, int unsigned gap, bit fixed,
                              result_t want);
    result_t predicted;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    mode_i = c.mode;
    bank_i = c.bank;
    stage_i = c.stage;
    start_reg_i = c.start_reg;
    reg_count_i = c.reg_count;
    bit_mask_i = c.marks;
    usage_unknown_i = c.unknown;
    usage_indexed_i = c.indexed;
    usage_float_count_i = c.use_float;
    usage_int_count_i = c.use_int;
    usage_bool_count_i = c.use_bool;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_command(c);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      fail_count++;
      if (reported < ReportLimit) begin
        reported++;
        $display("[%0t] %0d results never arrived", $realtime, pending_results.size());
      end
      pending_results.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(reg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_write_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_write_i = 1'b0;
    case (idx)
      REG_VERTEX_FLOAT_LIMIT: model_limits.vertex_float = value;
      REG_PIXEL_FLOAT_LIMIT:  model_limits.pixel_float = value;
      REG_INT_LIMIT:          model_limits.int_lim = value;
      REG_BOOL_LIMIT:         model_limits.bool_lim = value;
      default: ;
    endcase
  endtask

  // Result side: random stalls, one long hold on request, and the checks.
  initial begin : result_side
    int unsigned stall_left;
    result_t     want;
    stall_left = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_results && stall_left == 0) begin
        hold_results = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (reported < ReportLimit) begin
            reported++;
            $display("[%0t] result with no request outstanding", $realtime);
          end
        end else begin
          want = pending_results.pop_front();
          note_mismatch("dirty_marks", want.dirty_marks, dirty_marks_o);
          note_mismatch("plan_valid", want.plan_valid, plan_valid_o);
          note_mismatch("plan_float_count", want.plan_float, plan_float_count_o);
          note_mismatch("plan_int_count", want.plan_int, plan_int_count_o);
          note_mismatch("plan_bool_count", want.plan_bool, plan_bool_count_o);
          note_mismatch("full_struct", want.full_struct, full_struct_o);
        end
        stall_left = draw_gap(receiver_idle);
      end
    end
  end

  // Request side: reset, directed table, then the random phases.
  initial begin : request_side
    directed_row_t directed_rows [NumDirected];
    limits_t       phase_limits;
    tracker_cmd_t  c;
    int unsigned   counted;
    bit            sender_idle;
    bit            paused;

    rst_ni = 1'b0;
    cfg_write_i = 1'b0;
    cfg_index_i = REG_VERTEX_FLOAT_LIMIT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_CONST_SET;
    bank_i = '0;
    stage_i = 1'b0;
    start_reg_i = '0;
    reg_count_i = '0;
    bit_mask_i = '0;
    usage_unknown_i = 1'b0;
    usage_indexed_i = '0;
    usage_float_count_i = '0;
    usage_int_count_i = '0;
    usage_bool_count_i = '0;

    model_marks = '0;
    for (int i = 0; i < NumBanks; i++) model_water[i] = '0;
    model_limits.vertex_float = VERTEX_FLOAT_LIMIT_RST;
    model_limits.pixel_float = PIXEL_FLOAT_LIMIT_RST;
    model_limits.int_lim = INT_LIMIT_RST;
    model_limits.bool_lim = BOOL_LIMIT_RST;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table under the reset limits.
    // Plans straight after reset: empty, unknown usage, indexed bool usage.
    directed_rows[0] = '{command(MODE_BUILD_PLAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         typed_result(12'h000, 1, 0, 0, 0, 0)};
    directed_rows[1] = '{command(MODE_BUILD_PLAN, 0, 1, 0, 0, 0, 1, 0, 5, 5, 5), 1'b1,
                         typed_result(12'h000, 1, 224, 16, 16, 1)};
    directed_rows[2] = '{command(MODE_BUILD_PLAN, 7, 0, '1, '1, '1, 0, 3'b100, '1, '1, '1),
                         1'b1, typed_result(12'h000, 1, 256, 16, 16, 1)};
    // Saturating constant set to bank zero with all remaining fields at their top values.
    directed_rows[3] = '{command(MODE_CONST_SET, 0, 1, '1, '1, '1, 1, 3'b111, '1, '1, '1),
                         1'b1, typed_result(12'h001, 0, 0, 0, 0, 0)};
    directed_rows[4] = '{command(MODE_BUILD_PLAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         typed_result(12'h001, 1, 256, 0, 0, 0)};
    // Banks out of range change nothing.
    directed_rows[5] = '{command(MODE_CONST_SET, 6, 0, 4, 4, 0, 0, 0, 0, 0, 0), 1'b1,
                         typed_result(12'h001, 0, 0, 0, 0, 0)};
    directed_rows[6] = '{command(MODE_CONST_SET, 7, 0, '1, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    // Sums just at and just past the counter range.
    directed_rows[7] = '{command(MODE_CONST_SET, 2, 0, 65530, 5, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    directed_rows[8] = '{command(MODE_CONST_SET, 2, 0, 65530, 6, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    directed_rows[9] = '{command(MODE_CONST_SET, 3, 0, 100, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    directed_rows[10] = '{command(MODE_CONST_SET, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    directed_rows[11] = '{command(MODE_CONST_SET, 5, 0, 7, 9, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    // A smaller range must not lower the counter.
    directed_rows[12] = '{command(MODE_CONST_SET, 5, 0, 1, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    directed_rows[13] = '{command(MODE_CONST_SET, 1, 0, 3, 8, 0, 0, 0, 0, 0, 0), 1'b0, '0};
    directed_rows[14] = '{command(MODE_BUILD_PLAN, 0, 1, 0, 0, 0, 0, 0, '1, '1, '1), 1'b0, '0};
    directed_rows[15] = '{command(MODE_BUILD_PLAN, 0, 1, 0, 0, 0, 0, 3'b001, 0, 0, 0), 1'b0,
                          '0};
    directed_rows[16] = '{command(MODE_BUILD_PLAN, 0, 0, 0, 0, 0, 0, 3'b010, 0, 0, 0), 1'b0,
                          '0};
    directed_rows[17] = '{command(MODE_SET_MARKS, 0, 0, 0, 0, 12'hFFF, 0, 0, 0, 0, 0), 1'b1,
                          typed_result(12'hFFF, 0, 0, 0, 0, 0)};
    directed_rows[18] = '{command(MODE_CLEAR_MARKS, 0, 0, 0, 0, 12'hFFF, 0, 0, 0, 0, 0),
                          1'b1, typed_result(12'h000, 0, 0, 0, 0, 0)};
    directed_rows[19] = '{command(MODE_SET_MARKS, 0, 0, 0, 0, 12'h555, 0, 0, 0, 0, 0), 1'b0,
                          '0};
    directed_rows[20] = '{command(MODE_CLEAR_MARKS, 0, 0, 0, 0, 12'h00F, 0, 0, 0, 0, 0), 1'b0,
                          '0};
    directed_rows[21] = '{command(MODE_MARK_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                          typed_result(12'hFFF, 0, 0, 0, 0, 0)};
    // Unused modes report the mask only, whatever the other fields hold.
    directed_rows[22] = '{command(3'd5, 0, 0, 0, 0, 12'hFFF, 0, 0, 0, 0, 0), 1'b0, '0};
    directed_rows[23] = '{command(3'd6, 3, 1, '1, '1, '1, 1, 3'b111, '1, '1, '1), 1'b0, '0};
    directed_rows[24] = '{command(3'd7, 5, 1, 9, 9, 12'hFFF, 0, 0, 3, 2, 1), 1'b0, '0};

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, draw_gap(1'b1), directed_rows[i].fixed,
                   directed_rows[i].want);
    wait_drained();

    // Random phases, each with its own limits and idling pattern.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: phase_limits = '0;
        1: phase_limits = '1;
        4: phase_limits = '{16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF};
        3: phase_limits = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
        default: phase_limits = '{16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                                  16'($urandom_range(0, 40)), 16'($urandom_range(0, 40))};
      endcase
      write_register(REG_VERTEX_FLOAT_LIMIT, phase_limits.vertex_float);
      write_register(REG_PIXEL_FLOAT_LIMIT, phase_limits.pixel_float);
      write_register(REG_INT_LIMIT, phase_limits.int_lim);
      write_register(REG_BOOL_LIMIT, phase_limits.bool_lim);
      @(posedge clk_i);

      sender_idle = (ph != 1 && ph != 2);
      receiver_idle = (ph != 1 && ph != 3);
      // Back-to-back requests against a long result stall fill the block.
      if (ph == 2) hold_results = 1'b1;
      paused = 1'b0;
      counted = 0;
      while (counted < ItemsPerPhase) begin
        c = random_command(ph == NumPhases - 1);
        send_request(c, draw_gap(sender_idle), 1'b0, '0);
        if (!(c.mode > MODE_BUILD_PLAN || (c.mode == MODE_CONST_SET && c.bank >= NumBanks)))
          counted++;
        // Once, let the block run completely dry in the middle of a phase.
        if (ph == 3 && !paused && counted == ItemsPerPhase / 2) begin
          paused = 1'b1;
          wait_drained();
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
